@@ hw/rtl/ftoh_pkg.sv @@
package ftoh_pkg;

  // Longest fraction field; longer requests saturate here
  localparam int MAX_PRECISION = 32;
  localparam int LEN_W = $clog2(MAX_PRECISION + 1);
  // Character counter covers fraction digits and the longest fixed word
  localparam int IDX_W = (LEN_W > 4) ? LEN_W : 4;
  // Hex digits carried by the 24-bit padded mantissa
  localparam int HEX_DIGITS = 6;
  localparam logic [22:0] FRAC_MASK = 23'h7fffff;
  localparam logic [7:0] EXP_ALL_ONES = 8'hff;
  localparam logic [7:0] EXP_BIAS = 8'd127;
  localparam logic [7:0] EXP_SUB_MAG = 8'd126;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_I  = 8'h69;
  localparam logic [7:0] CH_LC_N  = 8'h6e;
  localparam logic [7:0] CH_LC_P  = 8'h70;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_ZERO,
    KIND_NAN,
    KIND_INF
  } ftoh_kind_t;

  // Decoded value after normalization
  typedef struct packed {
    logic              sign_en;
    logic              sign_neg;
    ftoh_kind_t        kind;
    logic [23:0]       mant;
    logic              exp_neg;
    logic [7:0]        exp_mag;
    logic signed [6:0] prec;
  } ftoh_norm_t;

  // Everything the serializer needs for one text
  typedef struct packed {
    logic             sign_en;
    logic             sign_neg;
    ftoh_kind_t       kind;
    logic [LEN_W-1:0] len;
    logic [23:0]      mant;
    logic             exp_neg;
    logic [2:0][3:0]  exp_dig;
    logic [1:0]       exp_cnt;
  } ftoh_rec_t;

  typedef enum logic [3:0] {
    EM_IDLE,
    EM_SIGN,
    EM_WORD,
    EM_LEAD,
    EM_DOT,
    EM_DIG,
    EM_PCH,
    EM_ESGN,
    EM_EDIG
  } ftoh_emit_st_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'b0, nib};
    end else begin
      c = CH_LC_A + {4'b0, nib} - 8'd10;
    end
    return c;
  endfunction

  // Last character position of a fixed word (zero, nan, inf)
  function automatic logic [IDX_W-1:0] word_last(input ftoh_kind_t kind);
    logic [IDX_W-1:0] v;
    if (kind == KIND_ZERO) begin
      v = IDX_W'(12);
    end else begin
      v = IDX_W'(2);
    end
    return v;
  endfunction

  // Fixed words: "0x0.000000p+0", "nan", "inf"
  function automatic logic [7:0] word_char(input ftoh_kind_t kind,
                                           input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    c = CH_ZERO;
    unique case (kind)
      KIND_ZERO: begin
        unique case (idx)
          IDX_W'(1):  c = CH_LC_X;
          IDX_W'(3):  c = CH_DOT;
          IDX_W'(10): c = CH_LC_P;
          IDX_W'(11): c = CH_PLUS;
          default:    c = CH_ZERO;
        endcase
      end
      KIND_NAN: begin
        unique case (idx)
          IDX_W'(1): c = CH_LC_A;
          default:   c = CH_LC_N;
        endcase
      end
      KIND_INF: begin
        unique case (idx)
          IDX_W'(0): c = CH_LC_I;
          IDX_W'(1): c = CH_LC_N;
          default:   c = CH_LC_F;
        endcase
      end
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/ftoh_decode.sv @@
module ftoh_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [31:0]          in_float_bits,
  input  logic signed [6:0]    in_precision,
  input  logic                 in_force_plus,
  output logic                 in_ready,
  output logic                 norm_valid,
  output ftoh_pkg::ftoh_norm_t norm_data,
  input  logic                 norm_ready
);
  import ftoh_pkg::*;

  logic              a_v_r;
  logic [31:0]       a_bits_r;
  logic signed [6:0] a_prec_r;
  logic              a_plus_r;
  logic              b_v_r;
  ftoh_norm_t        b_r;
  ftoh_norm_t        b_nxt;
  logic              a_rdy;
  logic              b_rdy;
  logic [7:0]        bexp;
  logic [22:0]       frac;
  logic [4:0]        top_pos;
  logic [4:0]        sh;
  logic [23:0]       shifted;

  // Advance a stage when it is empty or its content moves on
  assign b_rdy = !b_v_r || norm_ready;
  assign a_rdy = !a_v_r || b_rdy;
  assign in_ready = a_rdy;
  assign norm_valid = b_v_r;
  assign norm_data = b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_r <= in_valid;
      end
      if (b_rdy) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_bits_r <= in_float_bits;
      a_prec_r <= in_precision;
      a_plus_r <= in_force_plus;
    end
    if (b_rdy) begin
      b_r <= b_nxt;
    end
  end

  // Find the top set fraction bit for subnormal normalization
  always_comb begin
    frac = a_bits_r[22:0] & FRAC_MASK;
    top_pos = '0;
    for (int i = 0; i < 23; i++) begin
      if (frac[i]) begin
        top_pos = 5'(i);
      end
    end
    sh = 5'd23 - top_pos;
    shifted = {1'b0, frac} << sh;
  end

  // Classify and normalize
  always_comb begin
    bexp = a_bits_r[30:23];
    b_nxt.sign_neg = a_bits_r[31];
    b_nxt.sign_en = a_bits_r[31] || a_plus_r;
    b_nxt.prec = a_prec_r;
    b_nxt.mant = {frac, 1'b0};
    b_nxt.exp_neg = 1'b0;
    b_nxt.exp_mag = '0;
    if (bexp == EXP_ALL_ONES) begin
      b_nxt.kind = (frac != '0) ? KIND_NAN : KIND_INF;
    end else if (bexp == '0 && frac == '0) begin
      b_nxt.kind = KIND_ZERO;
    end else begin
      b_nxt.kind = KIND_NUM;
    end
    if (bexp == '0) begin
      b_nxt.mant = {shifted[22:0], 1'b0};
      b_nxt.exp_neg = 1'b1;
      b_nxt.exp_mag = EXP_SUB_MAG + {3'b0, sh};
    end else if (bexp >= EXP_BIAS) begin
      b_nxt.exp_mag = bexp - EXP_BIAS;
    end else begin
      b_nxt.exp_neg = 1'b1;
      b_nxt.exp_mag = EXP_BIAS - bexp;
    end
  end

endmodule

@@ hw/rtl/ftoh_prep.sv @@
module ftoh_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 norm_valid,
  input  ftoh_pkg::ftoh_norm_t norm_data,
  output logic                 norm_ready,
  output logic                 rec_valid,
  output ftoh_pkg::ftoh_rec_t  rec_data,
  input  logic                 rec_ready
);
  import ftoh_pkg::*;

  typedef struct packed {
    logic             sign_en;
    logic             sign_neg;
    ftoh_kind_t       kind;
    logic [LEN_W-1:0] len;
    logic [23:0]      mant;
    logic             exp_neg;
    logic             hund;
    logic [6:0]       rem;
    logic [1:0]       cnt;
  } ftoh_mid_t;

  logic       c_v_r;
  ftoh_mid_t  c_r;
  ftoh_mid_t  c_nxt;
  logic       d_v_r;
  ftoh_rec_t  d_r;
  ftoh_rec_t  d_nxt;
  logic       c_rdy;
  logic       d_rdy;
  logic [7:0] mag_low;
  logic [14:0] prod;
  logic [3:0] tens;
  logic [6:0] ones7;

  assign d_rdy = !d_v_r || rec_ready;
  assign c_rdy = !c_v_r || d_rdy;
  assign norm_ready = c_rdy;
  assign rec_valid = d_v_r;
  assign rec_data = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      if (c_rdy) begin
        c_v_r <= norm_valid;
      end
      if (d_rdy) begin
        d_v_r <= c_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy) begin
      c_r <= c_nxt;
    end
    if (d_rdy) begin
      d_r <= d_nxt;
    end
  end

  // Fraction length and hundreds split of the exponent
  always_comb begin
    c_nxt.sign_en = norm_data.sign_en;
    c_nxt.sign_neg = norm_data.sign_neg;
    c_nxt.kind = norm_data.kind;
    c_nxt.mant = norm_data.mant;
    c_nxt.exp_neg = norm_data.exp_neg;
    c_nxt.len = '0;
    if (norm_data.prec[6]) begin
      // trim trailing zero digits of the six held digits
      for (int i = 0; i < HEX_DIGITS; i++) begin
        if (norm_data.mant[23 - 4 * i -: 4] != 4'h0) begin
          c_nxt.len = LEN_W'(i + 1);
        end
      end
    end else if ({1'b0, norm_data.prec[5:0]} > 7'(MAX_PRECISION)) begin
      c_nxt.len = LEN_W'(MAX_PRECISION);
    end else begin
      c_nxt.len = LEN_W'(norm_data.prec[5:0]);
    end
    c_nxt.hund = (norm_data.exp_mag >= 8'd100);
    mag_low = c_nxt.hund ? (norm_data.exp_mag - 8'd100) : norm_data.exp_mag;
    c_nxt.rem = mag_low[6:0];
    if (c_nxt.hund) begin
      c_nxt.cnt = 2'd3;
    end else if (norm_data.exp_mag >= 8'd10) begin
      c_nxt.cnt = 2'd2;
    end else begin
      c_nxt.cnt = 2'd1;
    end
  end

  // Tens and ones by reciprocal multiply (exact below 100)
  always_comb begin
    prod = {8'b0, c_r.rem} * 15'd205;
    tens = prod[14:11];
    ones7 = c_r.rem - ({3'b0, tens} << 3) - ({3'b0, tens} << 1);
    d_nxt.sign_en = c_r.sign_en;
    d_nxt.sign_neg = c_r.sign_neg;
    d_nxt.kind = c_r.kind;
    d_nxt.len = c_r.len;
    d_nxt.mant = c_r.mant;
    d_nxt.exp_neg = c_r.exp_neg;
    d_nxt.exp_cnt = c_r.cnt;
    d_nxt.exp_dig[0] = {3'b0, c_r.hund};
    d_nxt.exp_dig[1] = tens;
    d_nxt.exp_dig[2] = ones7[3:0];
  end

endmodule

@@ hw/rtl/ftoh_emit.sv @@
module ftoh_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rec_valid,
  input  ftoh_pkg::ftoh_rec_t rec_data,
  output logic                rec_ready,
  output logic                out_valid,
  output logic [7:0]          out_character,
  output logic                out_last_char
);
  import ftoh_pkg::*;

  ftoh_emit_st_t    st_r;
  ftoh_emit_st_t    st_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  ftoh_rec_t        rec_r;
  logic             out_valid_r;
  logic [7:0]       out_character_r;
  logic             out_last_char_r;
  logic [7:0]       char_cur;
  logic             last_cur;
  logic             load;
  logic [1:0]       dig_sel;
  logic [3:0]       nib;

  function automatic ftoh_emit_st_t first_state(input ftoh_rec_t r);
    ftoh_emit_st_t s;
    if (r.sign_en) begin
      s = EM_SIGN;
    end else if (r.kind == KIND_NUM) begin
      s = EM_LEAD;
    end else begin
      s = EM_WORD;
    end
    return s;
  endfunction

  // Take the next transaction while the last character goes out
  assign rec_ready = (st_r == EM_IDLE) || last_cur;
  assign load = rec_ready && rec_valid;

  assign out_valid = out_valid_r;
  assign out_character = out_character_r;
  assign out_last_char = out_last_char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= EM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= (st_r != EM_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    out_character_r <= char_cur;
    out_last_char_r <= last_cur;
    if (load) begin
      rec_r <= rec_data;
    end
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r + 1'b1;
    unique case (st_r)
      EM_IDLE: begin
        idx_nxt = '0;
      end
      EM_SIGN: begin
        st_nxt = (rec_r.kind == KIND_NUM) ? EM_LEAD : EM_WORD;
        idx_nxt = '0;
      end
      EM_WORD: begin
        if (last_cur) begin
          st_nxt = EM_IDLE;
        end
      end
      EM_LEAD: begin
        if (idx_r == IDX_W'(2)) begin
          st_nxt = (rec_r.len != '0) ? EM_DOT : EM_PCH;
          idx_nxt = '0;
        end
      end
      EM_DOT: begin
        st_nxt = EM_DIG;
        idx_nxt = '0;
      end
      EM_DIG: begin
        if (idx_r == IDX_W'(rec_r.len) - 1'b1) begin
          st_nxt = EM_PCH;
          idx_nxt = '0;
        end
      end
      EM_PCH: begin
        st_nxt = EM_ESGN;
      end
      EM_ESGN: begin
        st_nxt = EM_EDIG;
        idx_nxt = '0;
      end
      EM_EDIG: begin
        if (last_cur) begin
          st_nxt = EM_IDLE;
        end
      end
      default: begin
        st_nxt = EM_IDLE;
      end
    endcase
    if (load) begin
      st_nxt = first_state(rec_data);
      idx_nxt = '0;
    end
  end

  // Pick the mantissa nibble for the current digit
  always_comb begin
    unique case (idx_r[2:0])
      3'd0:    nib = rec_r.mant[23:20];
      3'd1:    nib = rec_r.mant[19:16];
      3'd2:    nib = rec_r.mant[15:12];
      3'd3:    nib = rec_r.mant[11:8];
      3'd4:    nib = rec_r.mant[7:4];
      3'd5:    nib = rec_r.mant[3:0];
      default: nib = 4'h0;
    endcase
    dig_sel = idx_r[1:0] + (2'd3 - rec_r.exp_cnt);
  end

  // Current character
  always_comb begin
    char_cur = CH_ZERO;
    last_cur = 1'b0;
    unique case (st_r)
      EM_IDLE: begin
        char_cur = CH_ZERO;
      end
      EM_SIGN: begin
        char_cur = rec_r.sign_neg ? CH_MINUS : CH_PLUS;
      end
      EM_WORD: begin
        char_cur = word_char(rec_r.kind, idx_r);
        last_cur = (idx_r == word_last(rec_r.kind));
      end
      EM_LEAD: begin
        unique case (idx_r)
          IDX_W'(0): char_cur = CH_ZERO;
          IDX_W'(1): char_cur = CH_LC_X;
          default:   char_cur = CH_ONE;
        endcase
      end
      EM_DOT: begin
        char_cur = CH_DOT;
      end
      EM_DIG: begin
        char_cur = (idx_r < IDX_W'(HEX_DIGITS)) ? hex_char(nib) : CH_ZERO;
      end
      EM_PCH: begin
        char_cur = CH_LC_P;
      end
      EM_ESGN: begin
        char_cur = rec_r.exp_neg ? CH_MINUS : CH_PLUS;
      end
      EM_EDIG: begin
        char_cur = CH_ZERO + {4'b0, rec_r.exp_dig[dig_sel]};
        last_cur = (idx_r[1:0] == rec_r.exp_cnt - 2'd1);
      end
      default: begin
        char_cur = CH_ZERO;
      end
    endcase
  end

endmodule

@@ hw/rtl/float_to_hex_text_unit.sv @@
// Datapath: decode stages A and B, prep stages C and D, then the serializer's output register.
// Throughput: one character per cycle; a value holds the serializer while its text goes out:
// 3 to 10 + MAX_PRECISION characters (about 14 for a typical value at precision 6).
// Four pipeline stages buffer values; busy rises when they are full behind the serializer.
// Reset: synchronous, active low; clears all valid bits, the serializer and out_valid.
// The receiver cannot stall: every character strobes for exactly one cycle.
module float_to_hex_text_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       in_float_bits,
  input  logic signed [6:0] in_precision,
  input  logic              in_force_plus,
  output logic              out_valid,
  output logic [7:0]        out_character,
  output logic              out_last_char
);
  import ftoh_pkg::*;

  logic       in_ready;
  logic       norm_valid;
  ftoh_norm_t norm_data;
  logic       norm_ready;
  logic       rec_valid;
  ftoh_rec_t  rec_data;
  logic       rec_ready;

  assign busy = !in_ready;

  ftoh_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (start),
    .in_float_bits (in_float_bits),
    .in_precision  (in_precision),
    .in_force_plus (in_force_plus),
    .in_ready      (in_ready),
    .norm_valid    (norm_valid),
    .norm_data     (norm_data),
    .norm_ready    (norm_ready)
  );

  ftoh_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .norm_valid (norm_valid),
    .norm_data  (norm_data),
    .norm_ready (norm_ready),
    .rec_valid  (rec_valid),
    .rec_data   (rec_data),
    .rec_ready  (rec_ready)
  );

  ftoh_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec_valid     (rec_valid),
    .rec_data      (rec_data),
    .rec_ready     (rec_ready),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

endmodule

@@ hw/rtl/ftoh_checker.sv @@
module ftoh_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic [7:0]        out_character,
  input logic              out_last_char
);
  import ftoh_pkg::*;

  // Drop the strobe right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Keep one text contiguous until its last character
  a_text_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_char |=> out_valid)
    else $error("gap inside a text");

  // Open every text with a sign, a zero, or a special word
  a_text_opening: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!$past(out_valid) || $past(out_last_char)) |->
      (out_character == CH_MINUS || out_character == CH_PLUS ||
       out_character == CH_ZERO || out_character == CH_LC_N ||
       out_character == CH_LC_I))
    else $error("bad first character");

  // Follow the exponent marker with an exponent sign
  a_exp_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == CH_LC_P |=>
      out_valid && (out_character == CH_PLUS || out_character == CH_MINUS))
    else $error("exponent marker without sign");

endmodule

bind float_to_hex_text_unit ftoh_checker u_ftoh_checker (.*);
